### rtl/sssm_pkg.sv
package sssm_pkg;

  localparam int unsigned MaxOrderDef   = 16;
  localparam int unsigned ValueDepthDef = 256;

  localparam int unsigned ActionW = 4;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OrderW  = 5;
  localparam int unsigned AccW    = 48;

  localparam logic [ActionW-1:0] ActDiag   = 4'd0;
  localparam logic [ActionW-1:0] ActSetRow = 4'd1;
  localparam logic [ActionW-1:0] ActWiden  = 4'd2;
  localparam logic [ActionW-1:0] ActCommit = 4'd3;
  localparam logic [ActionW-1:0] ActSet    = 4'd4;
  localparam logic [ActionW-1:0] ActAdd    = 4'd5;
  localparam logic [ActionW-1:0] ActGet    = 4'd6;
  localparam logic [ActionW-1:0] ActLoadX  = 4'd7;
  localparam logic [ActionW-1:0] ActMul    = 4'd8;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StRange    = 3'd1;
  localparam logic [StatusW-1:0] StOutside  = 3'd2;
  localparam logic [StatusW-1:0] StBadRow   = 3'd3;
  localparam logic [StatusW-1:0] StOverflow = 3'd4;
  localparam logic [StatusW-1:0] StUncommit = 3'd5;

  // result item
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    result_value;
    logic               is_stored;
    logic [IdxW-1:0]    result_row;
    logic               last;
  } res_t;

  function automatic logic [ValW-1:0] sat32(input logic signed [AccW:0] v);
    if (v > $signed({{(AccW-ValW+1){1'b0}}, {1'b0, {(ValW-1){1'b1}}}}))
      return {1'b0, {(ValW-1){1'b1}}};
    else if (v < $signed({{(AccW-ValW+1){1'b1}}, {1'b1, {(ValW-1){1'b0}}}}))
      return {1'b1, {(ValW-1){1'b0}}};
    else
      return v[ValW-1:0];
  endfunction

endpackage

### rtl/skyline_symmetric_store_matvec_unit.sv
// single-entry actions: from accept to result, read, then modify/write, then output
// commit: offsets summed row by row, then the value store cleared entry by entry unless it overflows
// multiply: each entry read, multiplied, accumulated, mirrored if off-diagonal (shared
// multiplier), then rows out; one item at a time, the next after the last result left
// reset: the value store is cleared by a sweep over all VALUE_DEPTH entries after reset,
// during which no item is accepted; order resets to 16, profile to diagonal
module skyline_symmetric_store_matvec_unit #(
  parameter int unsigned MAX_ORDER   = sssm_pkg::MaxOrderDef,
  parameter int unsigned VALUE_DEPTH = sssm_pkg::ValueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sssm_pkg::OrderW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[3:0], row_index[7:4], column_index[11:8], operand[43:12], zero fill
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], result_value[34:3], is_stored[35], result_row[39:36]
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import sssm_pkg::*;

  localparam int unsigned AW  = $clog2(VALUE_DEPTH);
  localparam int unsigned CW  = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned RW  = $clog2(MAX_ORDER);
  localparam int unsigned NW  = $clog2(MAX_ORDER + 1);
  localparam int unsigned TW  = CW + NW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MOD, S_CSUM, S_CCLR, S_MRD, S_MMUL, S_MACC,
    S_MOUT, S_OUT
  } state_e;

  state_e state_q;
  logic [OrderW-1:0] order_q;
  logic committed_q;
  logic [RW-1:0] pf_q [MAX_ORDER];
  logic [CW-1:0] rs_q [MAX_ORDER];
  logic [ValW-1:0] x_q [MAX_ORDER];
  logic signed [AccW-1:0] acc_q [MAX_ORDER];
  logic [CW-1:0] offs_q [MAX_ORDER];

  logic [ActionW-1:0] act_q;
  logic [RW-1:0] hi_q, lo_q;
  logic [ValW-1:0] opv_q;
  logic [TW-1:0] tot_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] r_q, c_q;
  logic [NW-1:0] n_q;
  logic mirror_q;
  logic signed [2*ValW-1:0] prod_q;
  logic [RW-1:0] tgt_q;
  res_t res_q;
  logic ovalid_q, ovalid_d;

  // memory
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ValW-1:0] wdata, rdata;

  sssm_ram #(.Depth(VALUE_DEPTH), .Width(ValW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // input fields
  logic [ActionW-1:0] in_act;
  logic [IdxW-1:0] in_ri, in_ci;
  logic [ValW-1:0] in_op;
  assign in_act = s_axis_tdata_i[3:0];
  assign in_ri  = s_axis_tdata_i[7:4];
  assign in_ci  = s_axis_tdata_i[11:8];
  assign in_op  = s_axis_tdata_i[43:12];

  logic [NW-1:0] n_eff;
  always_comb begin
    if (order_q == '0) n_eff = NW'(1);
    else if ({1'b0, order_q} > (OrderW+1)'(MAX_ORDER)) n_eff = NW'(MAX_ORDER);
    else n_eff = NW'(order_q);
  end

  logic ri_ok, ci_ok;
  assign ri_ok = {1'b0, in_ri} < (IdxW+1)'(n_eff);
  assign ci_ok = {1'b0, in_ci} < (IdxW+1)'(n_eff);
  logic [RW-1:0] ri_s, ci_s, hi_s, lo_s;
  assign ri_s = RW'(in_ri);
  assign ci_s = RW'(in_ci);
  assign hi_s = (ri_s > ci_s) ? ri_s : ci_s;
  assign lo_s = (ri_s > ci_s) ? ci_s : ri_s;

  logic idle_free;
  assign idle_free = (state_q == S_IDLE) && !ovalid_q;
  assign s_axis_tready_o = idle_free;
  assign cfg_ready_o = idle_free && !s_axis_tvalid_i;

  // slot address for entry and walk
  logic [AW-1:0] ent_addr, walk_addr;
  assign ent_addr  = AW'(rs_q[hi_q] + CW'(lo_q - pf_q[hi_q]));
  assign walk_addr = AW'(rs_q[r_q] + CW'(c_q - pf_q[r_q]));

  // saturated add and rounded product
  logic signed [AccW:0] add_sum, acc_sum;
  logic signed [AccW-1:0] prod_r;
  logic signed [2*ValW:0] prod_rnd;
  assign add_sum = AccW'(0) + $signed({{(AccW-ValW+1){rdata[ValW-1]}}, rdata})
                 + $signed({{(AccW-ValW+1){opv_q[ValW-1]}}, opv_q});
  assign prod_rnd = {prod_q[2*ValW-1], prod_q} + (2*ValW+1)'(32768);
  assign prod_r = AccW'(prod_rnd >>> 16);
  assign acc_sum = {acc_q[tgt_q][AccW-1], acc_q[tgt_q]} + {prod_r[AccW-1], prod_r};
  logic signed [AccW-1:0] acc_sat;
  always_comb begin
    if (acc_sum > $signed({2'b00, {(AccW-1){1'b1}}})) acc_sat = {1'b0, {(AccW-1){1'b1}}};
    else if (acc_sum < $signed({2'b11, {(AccW-1){1'b0}}}))
      acc_sat = {1'b1, {(AccW-1){1'b0}}};
    else acc_sat = acc_sum[AccW-1:0];
  end

  // new entry value for set, add and get
  logic [ValW-1:0] mod_val;
  always_comb begin
    case (act_q)
      ActSet: mod_val = opv_q;
      ActAdd: mod_val = sat32(add_sum);
      default: mod_val = rdata;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = ent_addr; wdata = opv_q; raddr = ent_addr;
    case (state_q)
      S_CLEAR, S_CCLR: begin we = 1'b1; waddr = AW'(cnt_q); wdata = '0; end
      S_MOD: begin
        we = (act_q == ActSet) || (act_q == ActAdd);
        wdata = mod_val;
      end
      // hold the walk address so the value stays for the mirror product
      S_MRD, S_MMUL, S_MACC: raddr = walk_addr;
      default: ;
    endcase
  end

  // result of an item that is answered without a memory access
  res_t idle_res;
  always_comb begin
    idle_res = '0;
    idle_res.last = 1'b1;
    case (in_act)
      ActSetRow: begin
        if (!ri_ok) idle_res.status = StRange;
        else if (in_ci > in_ri) idle_res.status = StBadRow;
      end
      ActWiden: if (!ri_ok || !ci_ok) idle_res.status = StRange;
      ActSet, ActAdd, ActGet: begin
        if (!ri_ok || !ci_ok) idle_res.status = StRange;
        else if (!committed_q) begin
          idle_res.status = StUncommit;
          idle_res.is_stored = lo_s >= pf_q[hi_s];
        end else if (lo_s < pf_q[hi_s])
          idle_res.status = (in_act == ActGet) ? StOk : StOutside;
      end
      ActLoadX: if (!ri_ok) idle_res.status = StRange;
      ActMul: if (!committed_q) idle_res.status = StUncommit;
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    if ((state_q == S_OUT) || ((state_q == S_MOUT) && (!ovalid_q || m_axis_tready_i)))
      ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; order_q <= OrderW'(16); committed_q <= 1'b1;
      cnt_q <= '0; ovalid_q <= 1'b0; res_q <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        pf_q[i] <= RW'(i); rs_q[i] <= CW'(i); x_q[i] <= '0; acc_q[i] <= '0;
      end
    end else begin
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_data_i; committed_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(VALUE_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid_i && s_axis_tready_o) begin
          act_q <= in_act; hi_q <= hi_s; lo_q <= lo_s; opv_q <= in_op;
          res_q <= idle_res;
          case (in_act)
            ActDiag: begin
              for (int i = 0; i < MAX_ORDER; i++) pf_q[i] <= RW'(i);
              committed_q <= 1'b0; state_q <= S_OUT;
            end
            ActSetRow: begin
              if (ri_ok && !(in_ci > in_ri)) begin
                pf_q[ri_s] <= ci_s; committed_q <= 1'b0;
              end
              state_q <= S_OUT;
            end
            ActWiden: begin
              if (ri_ok && ci_ok) begin
                if (lo_s < pf_q[hi_s]) pf_q[hi_s] <= lo_s;
                committed_q <= 1'b0;
              end
              state_q <= S_OUT;
            end
            ActCommit: begin
              tot_q <= '0; r_q <= '0; n_q <= n_eff; state_q <= S_CSUM;
            end
            ActSet, ActAdd, ActGet: begin
              if (!ri_ok || !ci_ok || !committed_q || (lo_s < pf_q[hi_s]))
                state_q <= S_OUT;
              else state_q <= S_RD;
            end
            ActLoadX: begin
              if (ri_ok) x_q[ri_s] <= in_op;
              state_q <= S_OUT;
            end
            ActMul: begin
              if (!committed_q) state_q <= S_OUT;
              else begin
                for (int i = 0; i < MAX_ORDER; i++) acc_q[i] <= '0;
                n_q <= n_eff; r_q <= '0; c_q <= pf_q[0]; state_q <= S_MRD;
              end
            end
            default: ;
          endcase
        end
        S_RD: state_q <= S_MOD;
        S_MOD: begin
          res_q <= '{status: StOk, result_value: mod_val, is_stored: 1'b1,
                     result_row: '0, last: 1'b1};
          state_q <= S_OUT;
        end
        S_CSUM: begin
          // offsets accumulate one row per cycle
          offs_q[r_q] <= CW'(tot_q);
          tot_q <= tot_q + TW'(r_q - pf_q[r_q]) + TW'(1);
          if ({1'b0, r_q} == NW'(n_q - NW'(1))) begin
            if (tot_q + TW'(r_q - pf_q[r_q]) + TW'(1) > TW'(VALUE_DEPTH)) begin
              committed_q <= 1'b0; res_q.status <= StOverflow; state_q <= S_OUT;
            end else begin
              cnt_q <= '0; state_q <= S_CCLR;
            end
          end else r_q <= r_q + RW'(1);
        end
        S_CCLR: begin
          if (cnt_q == '0)
            for (int i = 0; i < MAX_ORDER; i++) rs_q[i] <= offs_q[i];
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(VALUE_DEPTH - 1)) begin
            committed_q <= 1'b1; state_q <= S_OUT;
          end
        end
        S_MRD: begin mirror_q <= 1'b0; state_q <= S_MMUL; end
        S_MMUL: begin
          // shared multiplier: main product, then mirror product
          prod_q <= $signed(rdata) * $signed(mirror_q ? x_q[r_q] : x_q[c_q]);
          tgt_q <= mirror_q ? c_q : r_q;
          state_q <= S_MACC;
        end
        S_MACC: begin
          acc_q[tgt_q] <= acc_sat;
          if (!mirror_q && c_q != r_q) begin
            mirror_q <= 1'b1; state_q <= S_MMUL;
          end else if (c_q != r_q) begin
            c_q <= c_q + RW'(1); state_q <= S_MRD;
          end else if ({1'b0, r_q} == NW'(n_q - NW'(1))) begin
            r_q <= '0; state_q <= S_MOUT;
          end else begin
            r_q <= r_q + RW'(1); c_q <= pf_q[r_q + RW'(1)]; state_q <= S_MRD;
          end
        end
        S_MOUT: if (!ovalid_q || m_axis_tready_i) begin
          res_q <= '{status: StOk,
                     result_value: sat32({acc_q[r_q][AccW-1], acc_q[r_q]}),
                     is_stored: 1'b0, result_row: IdxW'(r_q),
                     last: ({1'b0, r_q} == NW'(n_q - NW'(1)))};
          if ({1'b0, r_q} == NW'(n_q - NW'(1))) state_q <= S_IDLE;
          else r_q <= r_q + RW'(1);
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o = {res_q.result_row, res_q.is_stored, res_q.result_value,
                           res_q.status};
  assign m_axis_tlast_o = res_q.last;
endmodule

### rtl/sssm_ram.sv
module sssm_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### verif/tb_skyline_symmetric_store_matvec_unit.sv
`timescale 1ns / 100ps

module tb_skyline_symmetric_store_matvec_unit;
  import sssm_pkg::*;

  localparam int unsigned NMAX  = 16;
  localparam int unsigned DEPTH = 256;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [OrderW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // action[3:0], row_index[7:4], column_index[11:8], operand[43:12], zero fill
  logic [47:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // status[2:0], result_value[34:3], is_stored[35], result_row[39:36]
  logic [39:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  skyline_symmetric_store_matvec_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the block state
  logic [4:0]  m_order;
  logic [3:0]  m_first [NMAX];
  logic [8:0]  m_start [NMAX+1];
  logic signed [31:0] m_vals [DEPTH];
  logic signed [31:0] m_x [NMAX];
  logic signed [AccW-1:0] m_acc [NMAX];
  logic m_committed;

  res_t expected_results[$];
  int errors = 0;
  bit busy_idle = 1'b1;   // random idling on

  typedef struct {
    logic [3:0] act;
    logic [3:0] ri;
    logic [3:0] ci;
    logic [31:0] opnd;
    bit known;
    logic [2:0] st;
    logic [31:0] val;
    logic stored;
  } row_t;

  function automatic int unsigned eff_order();
    if (m_order < 1) return 1;
    if (m_order > NMAX) return NMAX;
    return m_order;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v[31:0];
  endfunction

  function automatic int unsigned slot_of(int unsigned hi, int unsigned lo);
    int unsigned k;
    k = m_start[hi] + lo - m_first[hi];
    return k < DEPTH ? k : 0;
  endfunction

  function automatic void acc_mac(int unsigned r, logic signed [31:0] a,
                                  logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [AccW+1:0] s;
    p = (64'(a) * 64'(b) + 64'sd32768) >>> 16;
    s = (AccW+2)'(m_acc[r]) + (AccW+2)'(p);
    if (s > AccMax) s = AccMax;
    if (s < AccMin) s = AccMin;
    m_acc[r] = s[AccW-1:0];
  endfunction

  function automatic logic [2:0] commit_profile();
    int unsigned n, total;
    logic [8:0] offs [NMAX+1];
    n = eff_order();
    total = 0;
    foreach (offs[i]) offs[i] = m_start[i];
    for (int unsigned r = 0; r < n; r++) begin
      offs[r] = total;
      total += r - m_first[r] + 1;
    end
    offs[n] = total;
    if (total > DEPTH) begin
      m_committed = 1'b0;
      return StOverflow;
    end
    // rows beyond n keep no offsets in a fresh layout
    for (int unsigned r = n + 1; r <= NMAX; r++) offs[r] = 0;
    foreach (offs[i]) m_start[i] = offs[i];
    foreach (m_vals[i]) m_vals[i] = 0;
    m_committed = 1'b1;
    return StOk;
  endfunction

  function automatic void push_res(logic [2:0] st, logic [31:0] v, logic stored,
                                   logic [3:0] row, logic lst);
    res_t r;
    r.status = st; r.result_value = v; r.is_stored = stored;
    r.result_row = row; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void reset_mirror();
    m_order = 16;
    foreach (m_first[i]) m_first[i] = i;
    foreach (m_start[i]) m_start[i] = 0;
    foreach (m_x[i]) m_x[i] = 0;
    foreach (m_acc[i]) m_acc[i] = 0;
    void'(commit_profile());
    m_committed = 1'b1;
  endfunction

  // predicts the results of one accepted item
  function automatic void predict_matvec(logic [3:0] act, logic [3:0] ri, logic [3:0] ci,
                                         logic signed [31:0] opv);
    int unsigned n, hi, lo, k;
    logic in_prof;
    n = eff_order();
    hi = ri > ci ? ri : ci;
    lo = ri > ci ? ci : ri;
    case (act)
      ActDiag: begin
        foreach (m_first[i]) m_first[i] = i;
        m_committed = 1'b0;
        push_res(StOk, 0, 0, 0, 1);
      end
      ActSetRow: begin
        if (ri >= n) push_res(StRange, 0, 0, 0, 1);
        else if (ci > ri) push_res(StBadRow, 0, 0, 0, 1);
        else begin
          m_first[ri] = ci;
          m_committed = 1'b0;
          push_res(StOk, 0, 0, 0, 1);
        end
      end
      ActWiden: begin
        if (ri >= n || ci >= n) push_res(StRange, 0, 0, 0, 1);
        else begin
          if (lo < m_first[hi]) m_first[hi] = lo;
          m_committed = 1'b0;
          push_res(StOk, 0, 0, 0, 1);
        end
      end
      ActCommit: push_res(commit_profile(), 0, 0, 0, 1);
      ActSet, ActAdd, ActGet: begin
        if (ri >= n || ci >= n) push_res(StRange, 0, 0, 0, 1);
        else begin
          in_prof = lo >= m_first[hi];
          if (!m_committed) push_res(StUncommit, 0, in_prof, 0, 1);
          else if (!in_prof) push_res(act == ActGet ? StOk : StOutside, 0, 0, 0, 1);
          else begin
            k = slot_of(hi, lo);
            if (act == ActSet) m_vals[k] = opv;
            else if (act == ActAdd) m_vals[k] = clip32(64'(m_vals[k]) + 64'(opv));
            push_res(StOk, m_vals[k], 1, 0, 1);
          end
        end
      end
      ActLoadX: begin
        if (ri >= n) push_res(StRange, 0, 0, 0, 1);
        else begin
          m_x[ri] = opv;
          push_res(StOk, 0, 0, 0, 1);
        end
      end
      ActMul: begin
        if (!m_committed) push_res(StUncommit, 0, 0, 0, 1);
        else begin
          foreach (m_acc[i]) m_acc[i] = 0;
          for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = m_first[r]; c <= r; c++) begin
              acc_mac(r, m_vals[slot_of(r, c)], m_x[c]);
              if (c != r) acc_mac(c, m_vals[slot_of(r, c)], m_x[r]);
            end
          for (int unsigned r = 0; r < n; r++)
            push_res(StOk, clip32(64'(m_acc[r])), 0, r, r + 1 == n);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] exp);
    $display("mismatch %s: got %h exp %h at %0t", what, got, exp, $time);
    errors++;
  endtask

  // output side: random stall, compare against oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni)
      m_axis_tready_i <= busy_idle ? ($urandom_range(99) >= 30) : 1'b1;
  end

  always @(posedge clk_i) begin
    res_t got, exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tdata_o[2:0];
      got.result_value = m_axis_tdata_o[34:3];
      got.is_stored = m_axis_tdata_o[35];
      got.result_row = m_axis_tdata_o[39:36];
      got.last = m_axis_tlast_o;
      if (expected_results.size() == 0)
        report_mismatch("unexpected item", m_axis_tdata_o, '0);
      else begin
        exp = expected_results.pop_front();
        if (got.status != exp.status) report_mismatch("status", got.status, exp.status);
        if (got.result_value != exp.result_value)
          report_mismatch("result_value", got.result_value, exp.result_value);
        if (got.is_stored != exp.is_stored)
          report_mismatch("is_stored", got.is_stored, exp.is_stored);
        if (got.result_row != exp.result_row)
          report_mismatch("result_row", got.result_row, exp.result_row);
        if (got.last != exp.last) report_mismatch("last", got.last, exp.last);
      end
    end
  end

  // valid is driven with blocking assignments so that back to back items can
  // drop and raise it in the same falling edge
  task automatic send_item(logic [3:0] act, logic [3:0] ri, logic [3:0] ci,
                           logic [31:0] opnd);
    if (busy_idle)
      while ($urandom_range(99) < 30) @(negedge clk_i);
    s_axis_tdata_i <= {4'b0, opnd, ci, ri, act};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_matvec(act, ri, ci, opnd);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 40) @(negedge clk_i);
  endtask

  task automatic write_order(logic [4:0] v);
    drain_results();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_order = v;
    m_committed = 1'b0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(4))
      0: return QMax;
      1: return QMin;
      2: return $urandom_range(32'h3ffff) - 32'h1ffff;
      default: return $urandom();
    endcase
  endfunction

  // random skyline build, fill, load x, multiply
  task automatic random_matvec_run();
    int unsigned n;
    n = eff_order();
    send_item(ActDiag, $urandom(), $urandom(), $urandom());
    repeat ($urandom_range(4)) begin
      if ($urandom_range(1)) send_item(ActSetRow, $urandom_range(n - 1),
                                       $urandom_range(n - 1), 0);
      else send_item(ActWiden, $urandom_range(n - 1), $urandom_range(n - 1), 0);
    end
    send_item(ActCommit, 0, 0, 0);
    repeat ($urandom_range(2, 6))
      send_item($urandom_range(1) ? ActSet : ActAdd, $urandom_range(n - 1),
                $urandom_range(n - 1), rand_value());
    repeat ($urandom_range(1, 4))
      send_item(ActLoadX, $urandom_range(n - 1), 0, rand_value());
    send_item(ActGet, $urandom_range(n - 1), $urandom_range(n - 1), 0);
    send_item(ActMul, 0, 0, 0);
  endtask

  row_t directed[] = '{
    '{ActGet,    0,  0,  0,            1, StOk,      0, 1},
    '{ActGet,    3, 15,  0,            1, StOk,      0, 0},
    '{ActSet,    5,  5,  32'h7fffffff, 1, StOk, 32'h7fffffff, 1},
    '{ActAdd,    5,  5,  32'h00010000, 1, StOk, 32'h7fffffff, 1},
    '{ActSet,    6,  6,  32'h80000000, 1, StOk, 32'h80000000, 1},
    '{ActAdd,    6,  6,  32'hffffffff, 1, StOk, 32'h80000000, 1},
    '{ActSet,    2,  7,  5,            1, StOutside, 0, 0},
    '{ActLoadX,  5,  0,  32'h00020000, 0, 0, 0, 0},
    '{ActLoadX,  6,  0,  32'hffff0000, 0, 0, 0, 0},
    '{ActMul,    0,  0,  0,            0, 0, 0, 0},
    '{ActSetRow, 3,  4,  0,            1, StBadRow,  0, 0},
    '{ActSetRow, 15, 0,  0,            1, StOk,      0, 0},
    '{ActGet,    1,  1,  0,            1, StUncommit, 0, 1},
    '{ActMul,    0,  0,  0,            1, StUncommit, 0, 0},
    '{ActWiden,  14, 2,  0,            1, StOk,      0, 0},
    '{ActCommit, 0,  0,  0,            1, StOk,      0, 0},
    '{ActSet,    15, 0,  32'h00018000, 1, StOk, 32'h00018000, 1},
    '{ActLoadX,  15, 0,  32'h00010000, 0, 0, 0, 0},
    '{ActLoadX,  0,  0,  32'h00010000, 0, 0, 0, 0},
    '{ActMul,    0,  0,  0,            0, 0, 0, 0},
    '{4'd9,      0,  0,  0,            0, 0, 0, 0},
    '{4'd15,     15, 15, 32'hffffffff, 0, 0, 0, 0},
    '{ActDiag,   0,  0,  0,            1, StOk,      0, 0}
  };

  initial begin
    res_t exp;
    reset_mirror();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table at full order
    busy_idle = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].known) begin
        exp.status = directed[i].st; exp.result_value = directed[i].val;
        exp.is_stored = directed[i].stored; exp.result_row = 0; exp.last = 1;
        send_item(directed[i].act, directed[i].ri, directed[i].ci, directed[i].opnd);
        if (expected_results[$] != exp)
          report_mismatch("directed row prediction", expected_results[$], exp);
      end else
        send_item(directed[i].act, directed[i].ri, directed[i].ci, directed[i].opnd);
    end
    busy_idle = 1'b1;

    // order extremes, range errors and a full profile
    write_order(1);
    send_item(ActLoadX, 1, 0, 1);
    send_item(ActGet, 0, 1, 0);
    send_item(ActCommit, 0, 0, 0);
    random_matvec_run();
    write_order(0);
    random_matvec_run();
    write_order(31);
    for (int r = 1; r < 16; r++) send_item(ActSetRow, r, 0, 0);
    send_item(ActCommit, 0, 0, 0);
    send_item(ActSet, 1, 1, 1);
    write_order(16);

    // random phase
    for (int ph = 0; ph < 4; ph++) begin
      busy_idle = (ph != 2);
      if (ph > 0) write_order(ph == 3 ? 16 : $urandom_range(2, 16));
      random_matvec_run();
      repeat (4) send_item($urandom_range(15), $urandom(), $urandom(), $urandom());
    end
    busy_idle = 1'b1;

    drain_results();
    if (errors == 0) $display("[skyline_symmetric_store_matvec_unit] OK");
    else $display("[skyline_symmetric_store_matvec_unit] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[skyline_symmetric_store_matvec_unit] ERROR");
    $finish;
  end

endmodule
